// File: design/sbe_pkg.sv
// Shared types and constants for the stack bytecode executor.
`default_nettype none
package sbe_pkg;

   typedef enum logic [4:0] {
      CMD_ADD = 5'd0, CMD_SUB = 5'd1, CMD_MUL = 5'd2, CMD_DIV = 5'd3,
      CMD_LT = 5'd4, CMD_GT = 5'd5, CMD_AND = 5'd6, CMD_OR = 5'd7,
      CMD_LOAD = 5'd8, CMD_POP = 5'd9, CMD_JF = 5'd10, CMD_JUMP = 5'd11,
      CMD_PRINT = 5'd12, CMD_LABEL = 5'd13, CMD_CALL = 5'd14, CMD_RET = 5'd15,
      CMD_GETL = 5'd16, CMD_SETL = 5'd17
   } cmd_type;

   localparam logic [2:0] FLT_OK    = 3'd0;
   localparam logic [2:0] FLT_UNDER = 3'd1;
   localparam logic [2:0] FLT_OVER  = 3'd2;
   localparam logic [2:0] FLT_DIV0  = 3'd3;
   localparam logic [2:0] FLT_FRAME = 3'd4;

   typedef struct packed {
      logic [4:0]  command;
      logic signed [31:0] constant;
   } req_type;

   typedef struct packed {
      logic [15:0] next_ip;
      logic        print_valid;
      logic signed [31:0] print_value;
      logic [2:0]  fault;
      logic [8:0]  stack_depth;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;   // capture request, issue reads
      logic exec;       // evaluate, start divider if needed
      logic div_step;   // one divider iteration
      logic commit;     // update state, fill output register
      logic rsp_take;   // output beat taken
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic need_div;
      logic div_done;
   } sts_type;

endpackage
`default_nettype wire

// File: design/sbe_ctrl.sv
// Sequencing state machine for the stack bytecode executor.
`default_nettype none
module sbe_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   input  wire sbe_pkg::sts_type sts,
   output sbe_pkg::ctl_type ctl
);
   import sbe_pkg::*;

   state_type state_ff, state_in;
   logic      full_ff, full_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         full_ff  <= full_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      full_in      = full_ff;
      ctl          = '0;
      req_stall    = 1'b1;
      ctl.rsp_take = full_ff & ~rsp_stall;
      if (ctl.rsp_take) full_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.load_req = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            ctl.exec = 1'b1;
            state_in = sts.need_div ? ST_DIV : ST_OUT;
         end
         ST_DIV: begin
            ctl.div_step = 1'b1;
            if (sts.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!full_ff || ctl.rsp_take) begin
               ctl.commit = 1'b1;
               full_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = full_ff;

   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> (!full_ff || ctl.rsp_take)) else $error("commit over full output");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_READ) else $error("accept lost");
   a_div_only: assert property (@(posedge clock) disable iff (reset)
      ctl.div_step |-> $past(state_ff) == ST_EXEC || $past(state_ff) == ST_DIV)
      else $error("stray divide step");
endmodule
`default_nettype wire

// File: design/sbe_dpath.sv
// Stacks, pointers, arithmetic and output register of the bytecode executor.
`default_nettype none
module sbe_dpath #(
   parameter int STACK_DEPTH    = 256,
   parameter int FRAME_DEPTH    = 64,
   parameter int PROG_ADDR_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire sbe_pkg::req_type req_data,
   output sbe_pkg::rsp_type rsp_data,
   input  wire sbe_pkg::ctl_type ctl,
   output sbe_pkg::sts_type sts
);
   import sbe_pkg::*;

   localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int FAW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
   localparam int FPW = $clog2(FRAME_DEPTH + 1);
   localparam int PW  = PROG_ADDR_BITS;

   logic [31:0]    stk_mem [STACK_DEPTH];
   logic [SPW-1:0] frm_mem [FRAME_DEPTH];

   logic [SPW-1:0] sp_ff;
   logic [FPW-1:0] fp_ff;
   logic [PW-1:0]  ip_ff;
   req_type        req_ff;
   logic [31:0]    a_ff, b_ff, l_ff;
   logic [SPW-1:0] frm_rd_ff;
   logic           slot_ok_ff;
   logic [SAW-1:0] slot_ff;
   rsp_type        rsp_ff;

   // result of evaluation
   logic [2:0]     flt_ff, flt_in;
   logic [31:0]    res_ff, res_in;
   logic           need_div_s;

   // divider
   logic [31:0] dq_ff, drem_ff, dd_ff;
   logic [5:0]  dcnt_ff;
   logic        dneg_ff;

   cmd_type cmd;
   assign cmd = cmd_type'(req_ff.command);

   // active frame base, read in the cycle after the frame pointer settles
   always_ff @(posedge clock) begin
      frm_rd_ff <= frm_mem[FAW'(fp_ff - 1'b1)];
   end

   logic [SPW-1:0] base_now;
   assign base_now = (fp_ff != '0) ? frm_rd_ff : '0;
   logic signed [33:0] idx_n;
   assign idx_n = $signed({2'b00, 32'(base_now)}) + 34'($signed(req_ff.constant));

   always_ff @(posedge clock) begin
      if (ctl.load_req) req_ff <= req_data;
      slot_ok_ff <= !idx_n[33] && (idx_n < $signed({2'b00, 32'(sp_ff)}));
      slot_ff    <= SAW'(idx_n);
   end

   // read stage: top and next, then the local slot on the second port
   logic [SAW-1:0] top_i, nxt_i;
   assign top_i = SAW'(sp_ff - 1'b1);
   assign nxt_i = SAW'(sp_ff - 2'd2);
   always_ff @(posedge clock) begin
      a_ff <= stk_mem[top_i];
      if (ctl.exec) l_ff <= stk_mem[slot_ff];
      else b_ff <= stk_mem[nxt_i];
   end

   logic full_s, emp_s, two_s, ffull_s;
   assign emp_s   = (sp_ff == '0);
   assign two_s   = (sp_ff >= SPW'(2));
   assign full_s  = (32'(sp_ff) >= 32'(STACK_DEPTH));
   assign ffull_s = (32'(fp_ff) >= 32'(FRAME_DEPTH));

   logic [63:0] prod;
   assign prod = a_ff * b_ff;

   always_comb begin
      flt_in = FLT_OK;
      res_in = '0;
      need_div_s = 1'b0;
      if (req_ff.command <= CMD_OR) begin
         if (!two_s) flt_in = FLT_UNDER;
         else begin
            case (cmd)
               CMD_ADD: res_in = b_ff + a_ff;
               CMD_SUB: res_in = b_ff - a_ff;
               CMD_MUL: res_in = prod[31:0];
               CMD_DIV: begin
                  if (a_ff == '0) flt_in = FLT_DIV0;
                  else need_div_s = 1'b1;
               end
               CMD_LT:  res_in = 32'($signed(b_ff) < $signed(a_ff));
               CMD_GT:  res_in = 32'($signed(b_ff) > $signed(a_ff));
               CMD_AND: res_in = 32'((b_ff != '0) && (a_ff != '0));
               default: res_in = 32'((b_ff != '0) || (a_ff != '0));
            endcase
         end
      end else begin
         case (cmd)
            CMD_LOAD:  if (full_s) flt_in = FLT_OVER;
            CMD_POP, CMD_JF, CMD_PRINT: if (emp_s) flt_in = FLT_UNDER;
            CMD_CALL:  if (ffull_s) flt_in = FLT_FRAME;
            CMD_RET: begin
               if (fp_ff == '0) flt_in = FLT_FRAME;
               else if (emp_s) flt_in = FLT_UNDER;
            end
            CMD_GETL: begin
               if (!slot_ok_ff) flt_in = FLT_FRAME;
               else if (full_s) flt_in = FLT_OVER;
            end
            CMD_SETL: begin
               if (emp_s) flt_in = FLT_UNDER;
               else if (!slot_ok_ff) flt_in = FLT_FRAME;
            end
            default: flt_in = FLT_OK;
         endcase
      end
   end

   // restoring divider on magnitudes, one bit a cycle
   logic [31:0] amag, bmag;
   assign amag = a_ff[31] ? -a_ff : a_ff;
   assign bmag = b_ff[31] ? -b_ff : b_ff;
   logic [32:0] trial;
   assign trial = {drem_ff, dq_ff[31]} - {1'b0, dd_ff};
   assign sts = '{need_div: need_div_s, div_done: (dcnt_ff == 6'd1)};

   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         flt_ff  <= flt_in;
         res_ff  <= res_in;
         dq_ff   <= bmag;
         drem_ff <= '0;
         dd_ff   <= amag;
         dneg_ff <= a_ff[31] ^ b_ff[31];
         dcnt_ff <= 6'd32;
      end else if (ctl.div_step) begin
         dcnt_ff <= dcnt_ff - 1'b1;
         if (!trial[32]) begin
            drem_ff <= trial[31:0];
            dq_ff   <= {dq_ff[30:0], 1'b1};
         end else begin
            drem_ff <= {drem_ff[30:0], dq_ff[31]};
            dq_ff   <= {dq_ff[30:0], 1'b0};
         end
         if (sts.div_done)
            res_ff <= dneg_ff ? -{dq_ff[30:0], !trial[32]} : {dq_ff[30:0], !trial[32]};
      end
   end

   // commit
   logic [PW-1:0] nip;
   logic [31:0]   cst;
   assign cst = req_ff.constant;
   always_comb begin
      nip = ip_ff + 1'b1;
      if (flt_ff != FLT_OK) nip = ip_ff;
      else begin
         case (cmd)
            CMD_JF:   if (a_ff == '0) nip = PW'(64'(cst));
            CMD_JUMP, CMD_CALL: nip = PW'(64'(cst));
            CMD_RET:  nip = PW'(64'(a_ff) + 64'd1);
            default:  nip = ip_ff + 1'b1;
         endcase
      end
   end

   logic [SPW-1:0] sp_new;
   always_comb begin
      sp_new = sp_ff;
      if (flt_ff == FLT_OK) begin
         if (req_ff.command <= CMD_OR) sp_new = sp_ff - 1'b1;
         else begin
            case (cmd)
               CMD_LOAD, CMD_GETL: sp_new = sp_ff + 1'b1;
               CMD_POP, CMD_PRINT, CMD_RET, CMD_SETL: sp_new = sp_ff - 1'b1;
               default: sp_new = sp_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit && flt_ff == FLT_OK) begin
         if (req_ff.command <= CMD_OR) stk_mem[nxt_i] <= res_ff;
         else begin
            case (cmd)
               CMD_LOAD: stk_mem[SAW'(sp_ff)] <= cst;
               CMD_GETL: stk_mem[SAW'(sp_ff)] <= l_ff;
               CMD_SETL: stk_mem[slot_ff] <= a_ff;
               default: ;
            endcase
         end
         if (cmd == CMD_CALL) frm_mem[FAW'(fp_ff)] <= sp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
         fp_ff <= '0;
         ip_ff <= '0;
      end else if (ctl.commit) begin
         sp_ff <= sp_new;
         ip_ff <= nip;
         if (flt_ff == FLT_OK && cmd == CMD_CALL) fp_ff <= fp_ff + 1'b1;
         if (flt_ff == FLT_OK && cmd == CMD_RET)  fp_ff <= fp_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_ff.next_ip     <= 16'(nip);
         rsp_ff.print_valid <= (flt_ff == FLT_OK) && (cmd == CMD_PRINT);
         rsp_ff.print_value <= ((flt_ff == FLT_OK) && (cmd == CMD_PRINT)) ? a_ff : '0;
         rsp_ff.fault       <= flt_ff;
         rsp_ff.stack_depth <= 9'(sp_new);
      end
   end
   assign rsp_data = rsp_ff;

   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      32'(sp_ff) <= 32'(STACK_DEPTH)) else $error("stack pointer out of range");
   a_fp_range: assert property (@(posedge clock) disable iff (reset)
      32'(fp_ff) <= 32'(FRAME_DEPTH)) else $error("frame pointer out of range");
   a_fault_hold: assert property (@(posedge clock) disable iff (reset)
      (ctl.commit && flt_ff != FLT_OK) |=> $stable(sp_ff) && $stable(ip_ff))
      else $error("state moved on fault");
   logic unused;
   assign unused = ctl.rsp_take;
endmodule
`default_nettype wire

// File: design/stack_bytecode_executor.sv
// Top level of the stack bytecode executor.
//
// One request beat carries one instruction (command, constant); one response
// beat returns next fetch address, print value, fault code and stack depth.
// Instructions are executed one at a time. From accept to response valid an
// instruction passes the request register, the stack memory read, then
// evaluate and commit; a divide adds the bit-serial divider between
// evaluate and commit. A new request is accepted in the cycle after the
// previous one commits.
// The response is held in an output register: while rsp_stall is high the
// beat holds and the next instruction runs up to commit, then waits.
// Reset clears stack pointer, frame pointer and instruction pointer; the
// stacks themselves are not cleared and need no clearing pass.
`default_nettype none
module stack_bytecode_executor #(
   parameter int STACK_DEPTH    = 256,
   parameter int FRAME_DEPTH    = 64,
   parameter int PROG_ADDR_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire sbe_pkg::req_type req_data,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output sbe_pkg::rsp_type rsp_data
);
   import sbe_pkg::*;

   ctl_type ctl;
   sts_type sts;

   sbe_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .sts, .ctl
   );

   sbe_dpath #(
      .STACK_DEPTH(STACK_DEPTH), .FRAME_DEPTH(FRAME_DEPTH),
      .PROG_ADDR_BITS(PROG_ADDR_BITS)
   ) u_dpath (
      .clock, .reset, .req_data, .rsp_data, .ctl, .sts
   );
endmodule
`default_nettype wire
